FILE: design/gss_pkg.sv
// ----------------------------------------------------------------------------
// gss_pkg
// Shared constants, codes and types of the generator safety supervisor.
// ----------------------------------------------------------------------------
package gss_pkg;

	// Configuration port geometry
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_CMD_TIMEOUT = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAX_RPM     = 3'd1;
	localparam logic [IDX_W-1:0] REG_MAX_LINK    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLUTCH_RPM  = 3'd3;
	localparam logic [IDX_W-1:0] REG_LOW_CHARGE  = 3'd4;
	localparam logic [IDX_W-1:0] REG_NOCHG_TMO   = 3'd5;
	localparam logic [IDX_W-1:0] REG_RPM_WINDOW  = 3'd6;

	// Configuration reset values
	localparam logic [15:0] RST_CMD_TIMEOUT = 16'd500;
	localparam logic [15:0] RST_MAX_RPM     = 16'd8000;
	localparam logic [9:0]  RST_MAX_LINK    = 10'd744;
	localparam logic [15:0] RST_CLUTCH_RPM  = 16'd3000;
	localparam logic [9:0]  RST_LOW_CHARGE  = 10'd782;
	localparam logic [15:0] RST_NOCHG_TMO   = 16'd2000;
	localparam logic [15:0] RST_RPM_WINDOW  = 16'd250;

	// Run states
	localparam logic [1:0] RUN_IDLE  = 2'd0;
	localparam logic [1:0] RUN_SPOOL = 2'd1;
	localparam logic [1:0] RUN_GEN   = 2'd2;
	localparam logic [1:0] RUN_FAULT = 2'd3;

	// Fault codes
	localparam logic [2:0] FLT_NONE      = 3'd0;
	localparam logic [2:0] FLT_KILL      = 3'd1;
	localparam logic [2:0] FLT_TIMEOUT   = 3'd2;
	localparam logic [2:0] FLT_OVERSPEED = 3'd3;
	localparam logic [2:0] FLT_OVERVOLT  = 3'd4;
	localparam logic [2:0] FLT_NOCHARGE  = 3'd5;

	// Rpm scale factor (pulses per ms to pulses per minute) and charge floor
	localparam logic [15:0] RPM_K         = 16'd60000;
	localparam logic [15:0] MIN_CHARGE_MA = 16'd100;

	// Request into the rpm unit and its answer
	typedef struct packed {
		logic        start;
		logic [31:0] dp;
		logic [31:0] dms;
	} rpm_req_t;

	typedef struct packed {
		logic        done;
		logic [15:0] rpm;
	} rpm_rsp_t;

endpackage

FILE: design/gss_rpm.sv
// ----------------------------------------------------------------------------
// gss_rpm
// Serial rpm unit: shift-add multiply of the pulse delta by 60000, one
// multiplier bit per cycle, then a restoring divide by the elapsed ms, one
// quotient bit per cycle, saturated at 16 bits.
// ----------------------------------------------------------------------------
module gss_rpm
	import gss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rpm_req_t req,
	output rpm_rsp_t rsp
);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_MUL  = 2'd1;
	localparam logic [1:0] U_DIV  = 2'd2;
	localparam logic [1:0] U_FIN  = 2'd3;

	logic [1:0]  st_q;
	logic [4:0]  cnt_q;
	logic [47:0] acc_q;
	logic [47:0] mcand_q;
	logic [47:0] dsh_q;
	logic [16:0] quo_q;
	logic        done_q;
	logic [15:0] rpm_q;
	logic        ge;
	logic [47:0] diff;

	// Compare and subtract the shifted divisor
	assign ge   = acc_q >= dsh_q;
	assign diff = acc_q - dsh_q;

	// Sequence multiply (16 steps), divide (17 steps) and finish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			cnt_q  <= 5'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				U_IDLE: begin
					if (req.start) begin
						cnt_q <= 5'd0;
						st_q  <= U_MUL;
					end
				end
				U_MUL: begin
					if (cnt_q == 5'd15) begin
						cnt_q <= 5'd16;
						st_q  <= U_DIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				U_DIV: begin
					if (cnt_q == 5'd0) begin
						st_q <= U_FIN;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				U_FIN: begin
					done_q <= 1'b1;
					st_q   <= U_IDLE;
				end
				default: begin
					st_q <= U_IDLE;
				end
			endcase
		end
	end

	// Datapath: accumulate partial products, then peel off quotient bits
	always_ff @(posedge clk) begin
		case (st_q)
			U_IDLE: begin
				acc_q   <= 48'd0;
				mcand_q <= {16'd0, req.dp};
				dsh_q   <= {req.dms, 16'd0};
			end
			U_MUL: begin
				if (RPM_K[cnt_q[3:0]]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q << 1;
			end
			U_DIV: begin
				if (ge) begin
					acc_q <= diff;
				end
				quo_q <= {quo_q[15:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			U_FIN: begin
				rpm_q <= quo_q[16] ? 16'hFFFF : quo_q[15:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.rpm  = rpm_q;

endmodule

FILE: design/generator_safety_supervisor.sv
// ----------------------------------------------------------------------------
// generator_safety_supervisor
// A request passes S_PREP and S_EVAL when no rpm update is due, and S_PREP,
// S_CALC and S_EVAL when one is (16 multiply steps plus 17 divide steps in
// the serial rpm unit). S_EVAL holds while the result register is full and
// not taken. One request at a time: the next is taken only back in S_IDLE.
// Reset (arst_n low, asynchronous) loads the register defaults and clears the
// held command, the charge timer, the rpm sampler and the rpm estimate.
// ----------------------------------------------------------------------------
module generator_safety_supervisor
	import gss_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// configuration
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [31:0]      now_ms,
	input  logic [31:0]      pulse_count,
	input  logic             safety_kill,
	input  logic             cmd_valid,
	input  logic             cmd_ice_on,
	input  logic             cmd_engine_kill,
	input  logic             cmd_dump_load,
	input  logic [15:0]      cmd_charge_ma,
	input  logic [7:0]       cmd_throttle,
	input  logic [9:0]       link_adc,
	input  logic [9:0]       charge_adc,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       run_state,
	output logic [2:0]       fault_code,
	output logic             ignition_kill,
	output logic [7:0]       throttle_duty,
	output logic             dump_load_out,
	output logic [15:0]      rpm_value
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PREP = 2'd1;
	localparam logic [1:0] S_CALC = 2'd2;
	localparam logic [1:0] S_EVAL = 2'd3;

	logic [1:0]  st_q;

	// configuration registers
	logic [15:0] cmd_timeout_q;
	logic [15:0] max_rpm_q;
	logic [9:0]  max_link_q;
	logic [15:0] clutch_rpm_q;
	logic [9:0]  low_charge_q;
	logic [15:0] nochg_tmo_q;
	logic [15:0] rpm_window_q;

	// current request
	logic [31:0] now_q;
	logic [31:0] pulse_q;
	logic        kill_q;
	logic [9:0]  link_q;
	logic [9:0]  charge_q;

	// held state
	logic        hc_ice_on_q;
	logic        hc_engine_kill_q;
	logic        hc_dump_q;
	logic [15:0] hc_charge_q;
	logic [7:0]  hc_thr_q;
	logic [31:0] hc_time_q;
	logic [31:0] lcs_q;
	logic [31:0] smp_time_q;
	logic [31:0] smp_pulse_q;
	logic [15:0] rpm_held_q;

	// timer flags computed ahead of the decision
	logic        cmd_late_q;
	logic        chg_late_q;

	// rpm unit
	rpm_req_t    req_q;
	rpm_rsp_t    rsp;

	// result register
	logic        out_valid_q;
	logic [1:0]  run_q;
	logic [2:0]  fault_q;
	logic        ign_q;
	logic [7:0]  thr_q;
	logic        dump_q;
	logic [15:0] rpm_out_q;

	logic        in_take;
	logic        out_free;
	logic        commit;
	logic [31:0] dms;
	logic [31:0] dp;
	logic        win_ok;
	logic        gen_req;
	logic        clutch;
	logic        low_chg;
	logic [2:0]  fault_d;
	logic [1:0]  run_d;
	logic [7:0]  thr_d;
	logic        dump_d;
	logic [31:0] lcs_d;

	assign in_ready = (st_q == S_IDLE);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign commit   = (st_q == S_EVAL) && out_free;

	// Sampler window: a zero window behaves as one ms
	assign dms    = now_q - smp_time_q;
	assign dp     = pulse_q - smp_pulse_q;
	assign win_ok = (dms >= {16'd0, rpm_window_q}) && (dms != 32'd0);

	// Decide faults and run state in priority order
	always_comb begin
		fault_d = FLT_NONE;
		run_d   = RUN_IDLE;
		thr_d   = 8'd0;
		dump_d  = 1'b0;
		lcs_d   = lcs_q;
		gen_req = hc_ice_on_q && (hc_charge_q > MIN_CHARGE_MA);
		clutch  = rpm_held_q >= clutch_rpm_q;
		low_chg = clutch && (charge_q < low_charge_q);
		if (kill_q || hc_engine_kill_q) begin
			fault_d = FLT_KILL;
		end else if (cmd_late_q) begin
			fault_d = FLT_TIMEOUT;
		end else if (rpm_held_q > max_rpm_q) begin
			fault_d = FLT_OVERSPEED;
		end else if (link_q > max_link_q) begin
			fault_d = FLT_OVERVOLT;
		end else if (!gen_req) begin
			dump_d = hc_dump_q;
			lcs_d  = 32'd0;
		end else begin
			if (low_chg) begin
				if (lcs_q == 32'd0) begin
					lcs_d = now_q;
				end else if (chg_late_q) begin
					fault_d = FLT_NOCHARGE;
				end
			end else begin
				lcs_d = 32'd0;
			end
			if (fault_d == FLT_NONE) begin
				run_d  = clutch ? RUN_GEN : RUN_SPOOL;
				thr_d  = hc_thr_q;
				dump_d = hc_dump_q;
			end
		end
		if (fault_d != FLT_NONE) begin
			run_d  = RUN_FAULT;
			thr_d  = 8'd0;
			dump_d = 1'b0;
		end
	end

	// Control, configuration and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q             <= S_IDLE;
			cmd_timeout_q    <= RST_CMD_TIMEOUT;
			max_rpm_q        <= RST_MAX_RPM;
			max_link_q       <= RST_MAX_LINK;
			clutch_rpm_q     <= RST_CLUTCH_RPM;
			low_charge_q     <= RST_LOW_CHARGE;
			nochg_tmo_q      <= RST_NOCHG_TMO;
			rpm_window_q     <= RST_RPM_WINDOW;
			hc_ice_on_q      <= 1'b0;
			hc_engine_kill_q <= 1'b0;
			hc_dump_q        <= 1'b0;
			hc_charge_q      <= 16'd0;
			hc_thr_q         <= 8'd0;
			hc_time_q        <= 32'd0;
			lcs_q            <= 32'd0;
			smp_time_q       <= 32'd0;
			smp_pulse_q      <= 32'd0;
			rpm_held_q       <= 16'd0;
			req_q            <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			req_q.start <= 1'b0;

			// write configuration
			if (cfg_we) begin
				case (cfg_index)
					REG_CMD_TIMEOUT: cmd_timeout_q <= cfg_data;
					REG_MAX_RPM:     max_rpm_q     <= cfg_data;
					REG_MAX_LINK:    max_link_q    <= cfg_data[9:0];
					REG_CLUTCH_RPM:  clutch_rpm_q  <= cfg_data;
					REG_LOW_CHARGE:  low_charge_q  <= cfg_data[9:0];
					REG_NOCHG_TMO:   nochg_tmo_q   <= cfg_data;
					REG_RPM_WINDOW:  rpm_window_q  <= cfg_data;
					default: begin
					end
				endcase
			end

			// drop the result once taken
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (in_take) begin
						if (cmd_valid) begin
							hc_ice_on_q      <= cmd_ice_on;
							hc_engine_kill_q <= cmd_engine_kill;
							hc_dump_q        <= cmd_dump_load;
							hc_charge_q      <= cmd_charge_ma;
							hc_thr_q         <= cmd_throttle;
							hc_time_q        <= now_ms;
						end
						st_q <= S_PREP;
					end
				end
				S_PREP: begin
					req_q.dp  <= dp;
					req_q.dms <= dms;
					if (smp_time_q == 32'd0) begin
						smp_time_q  <= now_q;
						smp_pulse_q <= pulse_q;
						st_q        <= S_EVAL;
					end else if (win_ok) begin
						smp_time_q  <= now_q;
						smp_pulse_q <= pulse_q;
						req_q.start <= 1'b1;
						st_q        <= S_CALC;
					end else begin
						st_q <= S_EVAL;
					end
				end
				S_CALC: begin
					if (rsp.done) begin
						rpm_held_q <= rsp.rpm;
						st_q       <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (commit) begin
						lcs_q       <= lcs_d;
						out_valid_q <= 1'b1;
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture the request, the timer flags and the result register
	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q    <= now_ms;
			pulse_q  <= pulse_count;
			kill_q   <= safety_kill;
			link_q   <= link_adc;
			charge_q <= charge_adc;
		end
		if (st_q == S_PREP) begin
			cmd_late_q <= (now_q - hc_time_q) > {16'd0, cmd_timeout_q};
			chg_late_q <= (now_q - lcs_q) > {16'd0, nochg_tmo_q};
		end
		if (commit) begin
			run_q     <= run_d;
			fault_q   <= fault_d;
			ign_q     <= (fault_d != FLT_NONE);
			thr_q     <= thr_d;
			dump_q    <= dump_d;
			rpm_out_q <= rpm_held_q;
		end
	end

	gss_rpm u_rpm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_q),
		.rsp    (rsp)
	);

	assign out_valid     = out_valid_q;
	assign run_state     = run_q;
	assign fault_code    = fault_q;
	assign ignition_kill = ign_q;
	assign throttle_duty = thr_q;
	assign dump_load_out = dump_q;
	assign rpm_value     = rpm_out_q;

endmodule

FILE: design/gss_checker.sv
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks of the generator safety supervisor, bound to the top.
// ----------------------------------------------------------------------------
module gss_checker
	import gss_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       run_state,
	input logic [2:0]       fault_code,
	input logic             ignition_kill,
	input logic [7:0]       throttle_duty,
	input logic             dump_load_out,
	input logic [15:0]      rpm_value
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fault_code) && $stable(run_state)
			&& $stable(rpm_value))
		else $error("stalled result changed or dropped");

	// Fault state goes with a nonzero fault code
	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((run_state == RUN_FAULT) == (fault_code != FLT_NONE)))
		else $error("run state and fault code disagree");

	// Fault drives ignition kill and drops throttle and dump load
	a_fault_safe: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_state == RUN_FAULT) |->
			ignition_kill && (throttle_duty == 8'd0) && !dump_load_out)
		else $error("fault outputs not safe");

	// Outside fault no ignition kill; idle has no throttle
	a_nofault: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (run_state != RUN_FAULT) |->
			!ignition_kill && ((run_state != RUN_IDLE) || (throttle_duty == 8'd0)))
		else $error("non-fault outputs wrong");

endmodule

bind generator_safety_supervisor gss_checker u_gss_checker (.*);

FILE: test/tb_generator_safety_supervisor.sv
// ----------------------------------------------------------------------------
// tb_generator_safety_supervisor
// Drives control ticks into the supervisor with random gaps and result
// backpressure, predicts every result from a behavioral copy of the state
// and configuration, and compares each result field by field. A directed
// warm-up covers each fault and the edge cases. Random phases under several
// register settings follow, the all-zero and the all-ones settings among them.
// ----------------------------------------------------------------------------
module tb_generator_safety_supervisor
	import gss_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 50;
	localparam int PHASE_TICKS    = 235;

	// One control tick and the supervisor outputs it produces
	typedef struct packed {
		logic [31:0] now;
		logic [31:0] pulses;
		logic        kill;
		logic        cmd_valid;
		logic        ice_on;
		logic        engine_kill;
		logic        dump;
		logic [15:0] charge_ma;
		logic [7:0]  throttle;
		logic [9:0]  link;
		logic [9:0]  charge;
	} tick_t;

	typedef struct packed {
		logic [1:0]  state;
		logic [2:0]  fault;
		logic        ign;
		logic [7:0]  thr;
		logic        dump;
		logic [15:0] rpm;
	} sup_out_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	tick_t            cur_tick = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       run_state;
	logic [2:0]       fault_code;
	logic             ignition_kill;
	logic [7:0]       throttle_duty;
	logic             dump_load_out;
	logic [15:0]      rpm_value;

	tick_t    tick_backlog[$];
	sup_out_t awaited_outputs[$];
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned run_left = 0;
	bit       steady_sender = 1'b0;

	// Supervisor limits as last written
	logic [15:0] lim_cmd_timeout, lim_max_rpm, lim_clutch, lim_nochg, lim_window;
	logic [9:0]  lim_max_link, lim_low_charge;

	// Supervisor state copy
	logic        sv_ice_on, sv_engine_kill, sv_dump;
	logic [15:0] sv_charge_ma;
	logic [7:0]  sv_throttle;
	logic [31:0] sv_cmd_time, sv_low_start, sv_sample_time, sv_sample_pulses;
	logic [15:0] sv_rpm;

	// Engine profile of the tick source
	logic [31:0] eng_now = 32'd0;
	logic [31:0] eng_pulses = 32'd0;
	logic [31:0] eng_origin_ms = 32'd0;
	logic [31:0] eng_origin_pulses = 32'd0;
	int          eng_rpm = 4000;
	bit          charge_short = 1'b0;
	bit          drought = 1'b0;

	generator_safety_supervisor dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.now_ms         (cur_tick.now),
		.pulse_count    (cur_tick.pulses),
		.safety_kill    (cur_tick.kill),
		.cmd_valid      (cur_tick.cmd_valid),
		.cmd_ice_on     (cur_tick.ice_on),
		.cmd_engine_kill(cur_tick.engine_kill),
		.cmd_dump_load  (cur_tick.dump),
		.cmd_charge_ma  (cur_tick.charge_ma),
		.cmd_throttle   (cur_tick.throttle),
		.link_adc       (cur_tick.link),
		.charge_adc     (cur_tick.charge),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.run_state      (run_state),
		.fault_code     (fault_code),
		.ignition_kill  (ignition_kill),
		.throttle_duty  (throttle_duty),
		.dump_load_out  (dump_load_out),
		.rpm_value      (rpm_value)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Latch the command, refresh the rpm estimate, then rank the faults
	function automatic sup_out_t supervise_tick(tick_t t);
		sup_out_t    o;
		logic [31:0] win, dms, dp, elapsed;
		logic [63:0] quot;
		logic        clutch;
		o = '0;
		o.state = RUN_IDLE;
		o.fault = FLT_NONE;
		if (t.cmd_valid) begin
			sv_ice_on = t.ice_on;
			sv_engine_kill = t.engine_kill;
			sv_dump = t.dump;
			sv_charge_ma = t.charge_ma;
			sv_throttle = t.throttle;
			sv_cmd_time = t.now;
		end
		if (sv_sample_time == 32'd0) begin
			sv_sample_time = t.now;
			sv_sample_pulses = t.pulses;
		end else begin
			win = (lim_window == 16'd0) ? 32'd1 : {16'd0, lim_window};
			dms = t.now - sv_sample_time;
			if (dms >= win) begin
				dp = t.pulses - sv_sample_pulses;
				quot = ({32'd0, dp} * {48'd0, RPM_K}) / {32'd0, dms};
				sv_rpm = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
				sv_sample_pulses = t.pulses;
				sv_sample_time = t.now;
			end
		end
		elapsed = t.now - sv_cmd_time;
		if (t.kill || sv_engine_kill) begin
			o.fault = FLT_KILL;
		end else if (elapsed > {16'd0, lim_cmd_timeout}) begin
			o.fault = FLT_TIMEOUT;
		end else if (sv_rpm > lim_max_rpm) begin
			o.fault = FLT_OVERSPEED;
		end else if (t.link > lim_max_link) begin
			o.fault = FLT_OVERVOLT;
		end else if (!(sv_ice_on && sv_charge_ma > MIN_CHARGE_MA)) begin
			o.state = RUN_IDLE;
			o.dump = sv_dump;
			sv_low_start = 32'd0;
		end else begin
			clutch = (sv_rpm >= lim_clutch);
			if (clutch && t.charge < lim_low_charge) begin
				elapsed = t.now - sv_low_start;
				if (sv_low_start == 32'd0) begin
					sv_low_start = t.now;
				end else if (elapsed > {16'd0, lim_nochg}) begin
					o.fault = FLT_NOCHARGE;
				end
			end else begin
				sv_low_start = 32'd0;
			end
			if (o.fault == FLT_NONE) begin
				o.state = clutch ? RUN_GEN : RUN_SPOOL;
				o.thr = sv_throttle;
				o.dump = sv_dump;
			end
		end
		if (o.fault != FLT_NONE) begin
			o.state = RUN_FAULT;
			o.ign = 1'b1;
			o.thr = 8'd0;
			o.dump = 1'b0;
		end
		o.rpm = sv_rpm;
		return o;
	endfunction

	function automatic tick_t mk_tick(logic [31:0] now, logic [31:0] pulses, logic kill,
			logic cv, logic on, logic ikill, logic dump, logic [15:0] ma,
			logic [7:0] thr, logic [9:0] link, logic [9:0] charge);
		tick_t t;
		t = '{now, pulses, kill, cv, on, ikill, dump, ma, thr, link, charge};
		return t;
	endfunction

	function automatic tick_t noise_tick();
		tick_t t;
		t.now = $urandom;
		t.pulses = $urandom;
		t.kill = 1'($urandom_range(0, 1));
		t.cmd_valid = 1'($urandom_range(0, 1));
		t.ice_on = 1'($urandom_range(0, 1));
		t.engine_kill = 1'($urandom_range(0, 1));
		t.dump = 1'($urandom_range(0, 1));
		t.charge_ma = 16'($urandom_range(0, 65535));
		t.throttle = 8'($urandom_range(0, 255));
		t.link = 10'($urandom_range(0, 1023));
		t.charge = 10'($urandom_range(0, 1023));
		return t;
	endfunction

	// Advance a plausible engine: steady speed, frequent commands, sane samples
	function automatic tick_t engine_tick();
		tick_t       t;
		int unsigned r, step;
		int          target;
		logic [31:0] span;
		logic [63:0] grown;
		if ($urandom_range(0, 29) == 0) begin
			case ($urandom_range(0, 5))
				0: target = 0;
				1: target = int'(lim_clutch) + $urandom_range(0, 400) - 200;
				2: target = $urandom_range(int'(lim_clutch), int'(lim_max_rpm));
				3: target = int'(lim_max_rpm) + $urandom_range(0, 400) - 200;
				4: target = $urandom_range(0, 80000);
				default: target = $urandom_range(2000, 6000);
			endcase
			eng_rpm = (target < 0) ? 0 : target;
			eng_origin_ms = eng_now;
			eng_origin_pulses = eng_pulses;
			charge_short = ($urandom_range(0, 2) == 0);
			drought = ($urandom_range(0, 9) == 0);
		end
		r = $urandom_range(0, 99);
		if (r < 70)
			step = $urandom_range(1, 25);
		else if (r < 90)
			step = $urandom_range(26, 300);
		else if (r < 97)
			step = $urandom_range(301, 700);
		else
			step = $urandom_range(701, 3000);
		eng_now = eng_now + step;
		span = eng_now - eng_origin_ms;
		grown = (64'(eng_rpm) * {32'd0, span}) / 64'd60000;
		eng_pulses = eng_origin_pulses + grown[31:0];

		t.now = eng_now;
		t.pulses = eng_pulses;
		t.kill = ($urandom_range(0, 99) < 3);
		t.cmd_valid = drought ? ($urandom_range(0, 49) == 0) : ($urandom_range(0, 99) < 35);
		t.ice_on = ($urandom_range(0, 99) < 85);
		t.engine_kill = ($urandom_range(0, 99) < 3);
		t.dump = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 9);
		if (r < 5)
			t.charge_ma = 16'($urandom_range(101, 5000));
		else if (r < 6)
			t.charge_ma = 16'($urandom_range(100, 101));
		else
			t.charge_ma = 16'($urandom_range(0, 65535));
		t.throttle = 8'($urandom_range(0, 255));
		t.link = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(0, int'(lim_max_link)));
		if (charge_short)
			t.charge = (lim_low_charge == 10'd0) ? 10'd0
				: 10'($urandom_range(0, int'(lim_low_charge) - 1));
		else if ($urandom_range(0, 99) < 85)
			t.charge = 10'($urandom_range(int'(lim_low_charge), 1023));
		else
			t.charge = 10'($urandom_range(0, 1023));
		return t;
	endfunction

	function automatic int unsigned pick_pause(int unsigned long_lo, int unsigned long_hi);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 58)
			return 0;
		else if (r < 91)
			return $urandom_range(1, 4);
		return $urandom_range(long_lo, long_hi);
	endfunction

	// Write one register and keep the local copy in step
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_CMD_TIMEOUT: lim_cmd_timeout = val;
			REG_MAX_RPM:     lim_max_rpm = val;
			REG_MAX_LINK:    lim_max_link = val[9:0];
			REG_CLUTCH_RPM:  lim_clutch = val;
			REG_LOW_CHARGE:  lim_low_charge = val[9:0];
			REG_NOCHG_TMO:   lim_nochg = val;
			REG_RPM_WINDOW:  lim_window = val;
			default: ;
		endcase
	endtask

	task automatic program_limits(logic [15:0] tmo, logic [15:0] max_rpm, logic [9:0] link,
			logic [15:0] clutch, logic [9:0] low, logic [15:0] nochg, logic [15:0] win);
		write_reg(REG_CMD_TIMEOUT, tmo);
		write_reg(REG_MAX_RPM, max_rpm);
		write_reg(REG_MAX_LINK, {6'd0, link});
		write_reg(REG_CLUTCH_RPM, clutch);
		write_reg(REG_LOW_CHARGE, {6'd0, low});
		write_reg(REG_NOCHG_TMO, nochg);
		write_reg(REG_RPM_WINDOW, win);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold until every request is in and every result is out, then settle
	task automatic wait_for_drain();
		while (tick_backlog.size() != 0 || in_valid || awaited_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string label, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	// Request driver: present the next tick, predict it on accept
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				awaited_outputs.push_back(supervise_tick(cur_tick));
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (tick_backlog.size() != 0) begin
					cur_tick <= tick_backlog.pop_front();
					in_valid <= 1'b1;
					send_gap <= steady_sender ? 0 : pick_pause(15, 40);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest prediction, vary backpressure
	always @(posedge clk or negedge arst_n) begin
		sup_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_outputs.size() == 0) begin
					$display("%0t: result with none expected, actual state %0d fault %0d",
						$time, run_state, fault_code);
					mismatches++;
				end else begin
					want = awaited_outputs.pop_front();
					check_field("run_state", 32'(want.state), 32'(run_state));
					check_field("fault_code", 32'(want.fault), 32'(fault_code));
					check_field("ignition_kill", 32'(want.ign), 32'(ignition_kill));
					check_field("throttle_duty", 32'(want.thr), 32'(throttle_duty));
					check_field("dump_load_out", 32'(want.dump), 32'(dump_load_out));
					check_field("rpm_value", 32'(want.rpm), 32'(rpm_value));
				end
			end
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if (run_left != 0) begin
				run_left <= run_left - 1;
				out_ready <= 1'b1;
			end else begin
				run_left <= $urandom_range(0, 40);
				stall_left <= pick_pause(20, 60);
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: drop the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("tb_generator_safety_supervisor failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		lim_cmd_timeout = RST_CMD_TIMEOUT;
		lim_max_rpm = RST_MAX_RPM;
		lim_max_link = RST_MAX_LINK;
		lim_clutch = RST_CLUTCH_RPM;
		lim_low_charge = RST_LOW_CHARGE;
		lim_nochg = RST_NOCHG_TMO;
		lim_window = RST_RPM_WINDOW;
		{sv_ice_on, sv_engine_kill, sv_dump, sv_charge_ma, sv_throttle} = '0;
		{sv_cmd_time, sv_low_start, sv_sample_time, sv_sample_pulses, sv_rpm} = '0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: sample at time zero, charge floor, spool and generate
		tick_backlog.push_back(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		tick_backlog.push_back(mk_tick(0, 0, 0, 1, 1, 0, 1, 100, 255, 744, 1023));
		tick_backlog.push_back(mk_tick(5, 0, 0, 1, 1, 0, 0, 101, 255, 744, 1023));
		tick_backlog.push_back(mk_tick(200, 16, 0, 1, 1, 0, 1, 65535, 128, 700, 1023));
		tick_backlog.push_back(mk_tick(255, 21, 0, 1, 1, 0, 1, 3000, 200, 700, 782));
		// Absent charge current while generating until the no-charge fault
		tick_backlog.push_back(mk_tick(300, 25, 0, 1, 1, 0, 1, 3000, 200, 700, 0));
		tick_backlog.push_back(mk_tick(700, 58, 0, 1, 1, 0, 1, 3000, 200, 700, 781));
		tick_backlog.push_back(mk_tick(1100, 91, 0, 1, 1, 0, 1, 3000, 200, 700, 100));
		tick_backlog.push_back(mk_tick(1500, 125, 0, 1, 1, 0, 1, 3000, 200, 700, 0));
		tick_backlog.push_back(mk_tick(1900, 158, 0, 1, 1, 0, 1, 3000, 200, 700, 0));
		tick_backlog.push_back(mk_tick(2300, 191, 0, 1, 1, 0, 1, 3000, 200, 700, 0));
		tick_backlog.push_back(mk_tick(2400, 200, 0, 1, 1, 0, 1, 3000, 200, 700, 0));
		tick_backlog.push_back(mk_tick(2410, 201, 0, 1, 1, 0, 1, 3000, 200, 700, 1023));
		// Kill line, commanded kill, overvoltage
		tick_backlog.push_back(mk_tick(2420, 202, 1, 0, 0, 0, 0, 0, 0, 700, 1023));
		tick_backlog.push_back(mk_tick(2430, 202, 0, 1, 1, 1, 1, 3000, 9, 700, 1023));
		tick_backlog.push_back(mk_tick(2440, 202, 0, 1, 1, 0, 1, 3000, 9, 744, 1023));
		tick_backlog.push_back(mk_tick(2450, 202, 0, 1, 1, 0, 0, 3000, 9, 745, 1023));
		tick_backlog.push_back(mk_tick(2460, 202, 0, 0, 0, 0, 0, 0, 0, 1023, 1023));
		// Saturated overspeed, recovery, then command timeout at its edge
		tick_backlog.push_back(mk_tick(2700, 5000, 0, 1, 1, 0, 1, 3000, 77, 700, 1023));
		tick_backlog.push_back(mk_tick(2960, 5022, 0, 1, 1, 0, 1, 3000, 77, 700, 1023));
		tick_backlog.push_back(mk_tick(3460, 5063, 0, 0, 0, 0, 0, 0, 0, 700, 1023));
		tick_backlog.push_back(mk_tick(3461, 5063, 0, 0, 0, 0, 0, 0, 0, 700, 1023));
		// Time and pulse counters wrapping
		tick_backlog.push_back(mk_tick(32'hFFFF_FF00, 32'hFFFF_FFF0, 0, 1, 1, 0, 1, 3000,
			50, 700, 1023));
		tick_backlog.push_back(mk_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 1, 0, 1, 3000,
			50, 700, 1023));
		tick_backlog.push_back(mk_tick(32'h0000_0080, 32'h0000_0010, 0, 1, 1, 0, 1, 3000,
			50, 700, 1023));
		eng_now = 32'h0000_0080;
		eng_pulses = 32'h0000_0010;
		eng_origin_ms = eng_now;
		eng_origin_pulses = eng_pulses;
		wait_for_drain();

		// Random phases, each under its own register setting
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: program_limits(16'($urandom_range(50, 2000)),
					16'($urandom_range(3000, 20000)),
					10'($urandom_range(300, 1023)), 16'($urandom_range(500, 3000)),
					10'($urandom_range(0, 1023)), 16'($urandom_range(10, 3000)),
					16'($urandom_range(1, 600)));
				1: program_limits(16'd0, 16'd0, 10'd0, 16'd0, 10'd0, 16'd0, 16'd0);
				2: program_limits(16'hFFFF, 16'hFFFF, 10'h3FF, 16'hFFFF, 10'h3FF, 16'hFFFF,
					16'hFFFF);
				3: program_limits(RST_CMD_TIMEOUT, RST_MAX_RPM, RST_MAX_LINK, RST_CLUTCH_RPM,
					RST_LOW_CHARGE, RST_NOCHG_TMO, RST_RPM_WINDOW);
				default: program_limits(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)),
					10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
					10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
					16'($urandom_range(1, 65535)));
			endcase
			steady_sender = (phase == 3);
			eng_origin_ms = eng_now;
			eng_origin_pulses = eng_pulses;
			for (int n = 0; n < PHASE_TICKS; n++) begin
				if ($urandom_range(0, 9) == 0)
					tick_backlog.push_back(noise_tick());
				else
					tick_backlog.push_back(engine_tick());
			end
			wait_for_drain();
		end

		if (mismatches == 0)
			$display("tb_generator_safety_supervisor passed");
		else
			$display("tb_generator_safety_supervisor failed");
		$finish;
	end

endmodule
